// ===== hdl/dmkv_pkg.sv =====
// ----------------------------------------------------------------------------
// Direct-mapped key/value table: shared definitions
// Request codes and field types used by the table unit and its hash unit.
// ----------------------------------------------------------------------------
package dmkv_pkg;

  localparam int LEN_W = 4;

  typedef logic [1:0]       req_type_t;
  typedef logic [LEN_W-1:0] key_len_t;

  localparam req_type_t OP_INSERT = 2'd0;
  localparam req_type_t OP_REMOVE = 2'd1;
  localparam req_type_t OP_SEARCH = 2'd2;

endpackage

// ===== hdl/dmkv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module dmkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dmkv_hash.sv =====
// ----------------------------------------------------------------------------
// Key hash unit
// Folds the key one byte at a time: add the byte, multiply by the byte, and
// reduce modulo the table size by a reciprocal multiply and a back-multiply.
// ----------------------------------------------------------------------------
module dmkv_hash #(
  parameter int TABLE_SIZE = 256,
  parameter int KEY_BYTES  = 8,
  localparam int IDX_W = $clog2(TABLE_SIZE),
  localparam int KEY_W = 8 * KEY_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [KEY_W-1:0]   key,
  input  dmkv_pkg::key_len_t len,
  output logic               done,
  output logic [IDX_W-1:0]   slot
);

  import dmkv_pkg::*;

  localparam int SUM_W   = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int PROD_W  = SUM_W + 8;
  localparam int SHIFT   = PROD_W + IDX_W;
  localparam int RECIP_W = PROD_W + 2;
  localparam int WIDE_W  = PROD_W + RECIP_W;
  localparam int BACK_W  = PROD_W + IDX_W + 1;

  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_64[RECIP_W-1:0];
  localparam logic [IDX_W:0]     MODULUS = (IDX_W + 1)'(TABLE_SIZE);

  localparam logic [2:0] HS_IDLE = 3'd0;
  localparam logic [2:0] HS_ADD  = 3'd1;
  localparam logic [2:0] HS_MUL  = 3'd2;
  localparam logic [2:0] HS_RED  = 3'd3;
  localparam logic [2:0] HS_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  sh_r, sh_nxt;
  key_len_t          cnt_r, cnt_nxt;
  key_len_t          len_r, len_nxt;
  logic [IDX_W-1:0]  h_r, h_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [PROD_W-1:0] q_r, q_nxt;

  logic [SUM_W-1:0]  sum;
  logic [WIDE_W-1:0] wide;
  logic [WIDE_W-1:0] wide_sh;
  logic [BACK_W-1:0] back;
  logic [BACK_W-1:0] rem;

  always_comb begin
    sum     = SUM_W'(h_r) + SUM_W'(sh_r[7:0]);
    wide    = WIDE_W'(p_r) * WIDE_W'(RECIP);
    wide_sh = wide >> SHIFT;
    back    = BACK_W'(q_r) * BACK_W'(MODULUS);
    rem     = BACK_W'(p_r) - back;

    state_nxt = state_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    h_nxt     = h_r;
    p_nxt     = p_r;
    q_nxt     = q_r;

    if (start) begin
      sh_nxt    = key;
      cnt_nxt   = '0;
      len_nxt   = len;
      h_nxt     = '0;
      state_nxt = (len == '0) ? HS_DONE : HS_ADD;
    end else begin
      case (state_r)
        HS_ADD: begin
          p_nxt     = PROD_W'(sum) * PROD_W'(sh_r[7:0]);
          state_nxt = HS_MUL;
        end
        HS_MUL: begin
          q_nxt     = wide_sh[PROD_W-1:0];
          state_nxt = HS_RED;
        end
        HS_RED: begin
          h_nxt     = rem[IDX_W-1:0];
          sh_nxt    = sh_r >> 8;
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = (cnt_r + 4'd1 == len_r) ? HS_DONE : HS_ADD;
        end
        HS_DONE: begin
          state_nxt = HS_IDLE;
        end
        default: begin
          state_nxt = HS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    len_r <= len_nxt;
    h_r   <= h_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
  end

  assign done = (state_r == HS_DONE);
  assign slot = h_r;

endmodule

// ===== hdl/direct_mapped_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// Direct-mapped key/value table unit
// Hashes a short key to one slot and inserts, removes or searches there.
//
//   Channel  Direction  Signals
//   in_      input      in_valid/in_ready, req_type, key_bytes, key_length,
//                       value_in
//   out_     output     out_valid/out_ready, success, found_value, slot_index
//
// An item with L hashed key bytes (L is the key length, capped at KEY_BYTES)
// goes from one accept to the next through the add, multiply and reduce
// steps of the hash unit for each byte, then a table read, a read-modify-write
// and the idle state in which the next item is taken.
// After reset a clearing pass writes every slot as empty, and no item is
// accepted meanwhile. A result waits in the output register while the next
// item is hashed; the table write stalls only when that register is still
// full.
// ----------------------------------------------------------------------------
module direct_mapped_key_value_table_unit #(
  parameter int TABLE_SIZE = 256,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmkv_pkg::req_type_t in_req_type,
  input  logic [63:0]         in_key_bytes,
  input  dmkv_pkg::key_len_t  in_key_length,
  input  logic [31:0]         in_value_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_success,
  output logic [31:0]         out_found_value,
  output logic [7:0]          out_slot_index
);

  import dmkv_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int ENT_W = 1 + LEN_W + KEY_W + VALUE_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_SIZE - 1);
  localparam key_len_t         KEY_LEN_MAX = LEN_W'(KEY_BYTES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      clr_idx_r, clr_idx_nxt;
  req_type_t             op_r, op_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  key_len_t              len_r, len_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_success_r, out_success_nxt;
  logic [31:0]           out_found_r, out_found_nxt;
  logic [7:0]            out_slot_r, out_slot_nxt;

  logic                  accept;
  key_len_t              sat_len;
  logic [KEY_W-1:0]      masked_key;
  logic [63:0]           value_64;
  logic                  hash_done;
  logic [IDX_W-1:0]      slot;
  logic [15:0]           slot_16;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic [ENT_W-1:0]      ram_wr_data;
  logic                  ram_rd_en;
  logic [ENT_W-1:0]      ram_rd_data;

  logic                  ent_valid;
  key_len_t              ent_len;
  logic [KEY_W-1:0]      ent_key;
  logic [VALUE_BITS-1:0] ent_val;
  logic [63:0]           ent_val_64;
  logic                  match;
  logic                  out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    sat_len  = (in_key_length > KEY_LEN_MAX) ? KEY_LEN_MAX : in_key_length;
    value_64 = 64'(in_value_in);
    for (int i = 0; i < KEY_BYTES; i++) begin
      masked_key[8*i +: 8] = (LEN_W'(i) < sat_len) ? in_key_bytes[8*i +: 8] : 8'h00;
    end
  end

  dmkv_hash #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (masked_key),
    .len   (sat_len),
    .done  (hash_done),
    .slot  (slot)
  );

  dmkv_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  assign ent_valid  = ram_rd_data[ENT_W-1];
  assign ent_len    = ram_rd_data[ENT_W-2 -: LEN_W];
  assign ent_key    = ram_rd_data[VALUE_BITS +: KEY_W];
  assign ent_val    = ram_rd_data[VALUE_BITS-1:0];
  assign ent_val_64 = 64'(ent_val);
  assign match      = ent_valid && (ent_len == len_r) && (ent_key == key_r);
  assign out_free   = !out_valid_r || out_ready;
  assign slot_16    = 16'(slot);

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    len_nxt         = len_r;
    val_nxt         = val_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_success_nxt = out_success_r;
    out_found_nxt   = out_found_r;
    out_slot_nxt    = out_slot_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = slot;
    ram_wr_data     = ram_rd_data;
    ram_rd_en       = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r;
        ram_wr_data = '0;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_req_type;
          key_nxt   = masked_key;
          len_nxt   = sat_len;
          val_nxt   = value_64[VALUE_BITS-1:0];
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          ram_rd_en = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b0;
          out_found_nxt   = '0;
          out_slot_nxt    = slot_16[7:0];
          state_nxt       = ST_IDLE;
          case (op_r)
            OP_INSERT: begin
              if (!ent_valid) begin
                ram_wr_en       = 1'b1;
                ram_wr_data     = {1'b1, len_r, key_r, val_r};
                out_success_nxt = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (match) begin
                ram_wr_en       = 1'b1;
                ram_wr_data     = {1'b0, ram_rd_data[ENT_W-2:0]};
                out_success_nxt = 1'b1;
              end
            end
            OP_SEARCH: begin
              if (match) begin
                out_found_nxt   = ent_val_64[31:0];
                out_success_nxt = 1'b1;
              end
            end
            default: begin
              out_success_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    len_r         <= len_nxt;
    val_r         <= val_nxt;
    out_success_r <= out_success_nxt;
    out_found_r   <= out_found_nxt;
    out_slot_r    <= out_slot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_success_r;
  assign out_found_value = out_found_r;
  assign out_slot_index  = out_slot_r;

  a_hash_done_in_hash: assert property (
    @(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == ST_HASH)
  ) else $error("hash unit finished outside the hash wait state");

  a_result_after_check: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CHECK)
  ) else $error("result appeared without a table check");

  a_found_needs_success: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_success_r) |-> (out_found_r == '0)
  ) else $error("nonzero found value on a failed item");

  a_no_write_while_hashing: assert property (
    @(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == ST_CLEAR || state_r == ST_CHECK)
  ) else $error("table written outside clearing or check");

endmodule
